@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked, with async reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/ius_pkg.sv @@
// ----------------------------------------------------------------------------
// ius_pkg
// Types, constants and helpers of the 2x linear image upscaler.
// ----------------------------------------------------------------------------
package ius_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int PIX_W    = 8;
	localparam int SIZE_W   = 11;
	localparam int COORD_W  = 10;
	localparam int REGIDX_W = 2;

	// configuration register indexes
	localparam logic [REGIDX_W-1:0] REG_INTERP_MODE   = 2'd0;
	localparam logic [REGIDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
	localparam logic [REGIDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

	// quad slots, in emission order
	localparam logic [3:0] QSEL_ABOVE_LEFT = 4'b0001;
	localparam logic [3:0] QSEL_ABOVE      = 4'b0010;
	localparam logic [3:0] QSEL_LEFT       = 4'b0100;
	localparam logic [3:0] QSEL_HERE       = 4'b1000;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic             interp_mode;
		logic [COL_W-1:0] col_last;
		logic [ROW_W-1:0] row_last;
	} cfg_t;

	typedef struct packed {
		pix_t             ul;
		pix_t             up;
		pix_t             lf;
		pix_t             p;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             frame_end;
		logic [3:0]       mask;
	} quad_job_t;

	function automatic pix_t avg2(pix_t a, pix_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PIX_W:1];
	endfunction

	function automatic logic [COL_W-1:0] col_last_idx(logic [SIZE_W-1:0] v);
		if (v < SIZE_W'(2))
			return COL_W'(1);
		else if (32'(v) > MAX_WIDTH)
			return COL_W'(MAX_WIDTH - 1);
		else
			return COL_W'(v - SIZE_W'(1));
	endfunction

	function automatic logic [ROW_W-1:0] row_last_idx(logic [SIZE_W-1:0] v);
		if (v < SIZE_W'(2))
			return ROW_W'(1);
		else if (32'(v) > MAX_HEIGHT)
			return ROW_W'(MAX_HEIGHT - 1);
		else
			return ROW_W'(v - SIZE_W'(1));
	endfunction

endpackage

@@ hw/rtl/ius_ifs.sv @@
// ----------------------------------------------------------------------------
// ius channel interfaces
// Pixel input, quad output and configuration write channels.
// ----------------------------------------------------------------------------
interface ius_pixel_if;
	logic                   valid;
	logic                   ready;
	logic [ius_pkg::PIX_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface ius_quad_if;
	logic                        valid;
	logic                        ready;
	logic [ius_pkg::PIX_W-1:0]   quad_top_left;
	logic [ius_pkg::PIX_W-1:0]   quad_top_right;
	logic [ius_pkg::PIX_W-1:0]   quad_bottom_left;
	logic [ius_pkg::PIX_W-1:0]   quad_bottom_right;
	logic [ius_pkg::COORD_W-1:0] quad_row;
	logic [ius_pkg::COORD_W-1:0] quad_column;
	logic                        last_of_run;
	logic                        frame_done;
	modport source (output valid, output quad_top_left, output quad_top_right,
		output quad_bottom_left, output quad_bottom_right, output quad_row,
		output quad_column, output last_of_run, output frame_done, input ready);
	modport sink (input valid, input quad_top_left, input quad_top_right,
		input quad_bottom_left, input quad_bottom_right, input quad_row,
		input quad_column, input last_of_run, input frame_done, output ready);
endinterface

interface ius_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ius_pkg::REGIDX_W-1:0] index;
	logic [ius_pkg::SIZE_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ius_line_buf.sv @@
// ----------------------------------------------------------------------------
// ius_line_buf
// Line buffer, raster counters and neighbor registers; builds one quad job
// per accepted pixel.
// ----------------------------------------------------------------------------
module ius_line_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ius_pkg::cfg_t        cfg,
	ius_pixel_if.sink            pix,
	output logic                 job_valid,
	output ius_pkg::quad_job_t   job,
	input  logic                 job_ready
);

	ius_pkg::pix_t line_mem [ius_pkg::MAX_WIDTH];

	logic [ius_pkg::COL_W-1:0] col_q;
	logic [ius_pkg::ROW_W-1:0] row_q;
	ius_pkg::pix_t             lf_q;
	ius_pkg::pix_t             ul_q;

	logic                      s1_valid_q;
	ius_pkg::pix_t             up_s1;
	ius_pkg::pix_t             p_s1;
	ius_pkg::pix_t             lf_s1;
	logic [ius_pkg::ROW_W-1:0] row_s1;
	logic [ius_pkg::COL_W-1:0] col_s1;
	logic                      frame_end_s1;
	logic [3:0]                mask_s1;

	logic       accept;
	logic       s1_leave;
	logic       last_col;
	logic       last_row;
	logic       interior;
	logic [3:0] mask_d;

	assign last_col = col_q >= cfg.col_last;
	assign last_row = row_q >= cfg.row_last;
	assign interior = (row_q != '0) && (col_q != '0);

	always_comb begin
		mask_d = '0;
		if (!cfg.interp_mode)
			mask_d = ius_pkg::QSEL_HERE;
		else if (interior) begin
			mask_d = ius_pkg::QSEL_ABOVE_LEFT;
			if (last_col)
				mask_d = mask_d | ius_pkg::QSEL_ABOVE;
			if (last_row)
				mask_d = mask_d | ius_pkg::QSEL_LEFT;
			if (last_col && last_row)
				mask_d = mask_d | ius_pkg::QSEL_HERE;
		end
	end

	assign s1_leave  = s1_valid_q && ((mask_s1 == '0) || job_ready);
	assign pix.ready = !s1_valid_q || s1_leave;
	assign accept    = pix.valid && pix.ready;
	assign job_valid = s1_valid_q && (mask_s1 != '0);

	// read-first: the row above comes out while this pixel replaces it
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1         <= line_mem[col_q];
			line_mem[col_q] <= pix.pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1         <= pix.pixel;
			lf_s1        <= lf_q;
			row_s1       <= row_q;
			col_s1       <= col_q;
			frame_end_s1 <= last_col && last_row;
			mask_s1      <= mask_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			lf_q       <= '0;
			ul_q       <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				lf_q <= pix.pixel;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (s1_leave)
				ul_q <= up_s1;
			if (accept)
				s1_valid_q <= 1'b1;
			else if (s1_leave)
				s1_valid_q <= 1'b0;
		end
	end

	always_comb begin
		job.ul        = ul_q;
		job.up        = up_s1;
		job.lf        = lf_s1;
		job.p         = p_s1;
		job.row       = row_s1;
		job.col       = col_s1;
		job.frame_end = frame_end_s1;
		job.mask      = mask_s1;
	end

endmodule

@@ hw/rtl/ius_quad_seq.sv @@
// ----------------------------------------------------------------------------
// ius_quad_seq
// Walks the pending quads of one job, computes each quad and holds it in
// the output register.
// ----------------------------------------------------------------------------
module ius_quad_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  ius_pkg::quad_job_t job,
	output logic               job_ready,
	ius_quad_if.source         quad
);

	logic               s2_valid_q;
	ius_pkg::quad_job_t job_s2;
	logic [3:0]         pend_s2;

	logic                        out_valid_q;
	ius_pkg::pix_t               tl_q;
	ius_pkg::pix_t               tr_q;
	ius_pkg::pix_t               bl_q;
	ius_pkg::pix_t               br_q;
	logic [ius_pkg::COORD_W-1:0] qrow_q;
	logic [ius_pkg::COORD_W-1:0] qcol_q;
	logic                        last_q;
	logic                        done_q;

	logic [3:0]                sel;
	logic [3:0]                rem;
	logic                      emit;
	logic                      s2_done;
	ius_pkg::pix_t             a, b, c, d;
	logic [ius_pkg::ROW_W-1:0] r;
	logic [ius_pkg::COL_W-1:0] k;
	logic                      fd;

	assign sel       = pend_s2 & (~pend_s2 + 4'd1);
	assign rem       = pend_s2 & ~sel;
	assign emit      = s2_valid_q && (!out_valid_q || quad.ready);
	assign s2_done   = emit && (rem == '0);
	assign job_ready = !s2_valid_q || s2_done;

	always_comb begin
		a  = job_s2.p;
		b  = job_s2.p;
		c  = job_s2.p;
		d  = job_s2.p;
		r  = job_s2.row;
		k  = job_s2.col;
		fd = 1'b0;
		unique case (sel)
			ius_pkg::QSEL_ABOVE_LEFT: begin
				a = job_s2.ul;
				b = job_s2.up;
				c = job_s2.lf;
				r = job_s2.row - 1'b1;
				k = job_s2.col - 1'b1;
			end
			ius_pkg::QSEL_ABOVE: begin
				a = job_s2.up;
				b = job_s2.up;
				r = job_s2.row - 1'b1;
			end
			ius_pkg::QSEL_LEFT: begin
				a = job_s2.lf;
				c = job_s2.lf;
				k = job_s2.col - 1'b1;
			end
			default: begin
				fd = job_s2.frame_end;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tl_q   <= a;
			tr_q   <= ius_pkg::avg2(a, b);
			bl_q   <= ius_pkg::avg2(a, c);
			br_q   <= ius_pkg::avg2(ius_pkg::avg2(a, b), ius_pkg::avg2(c, d));
			qrow_q <= ius_pkg::COORD_W'(r);
			qcol_q <= ius_pkg::COORD_W'(k);
			last_q <= rem == '0;
			done_q <= fd;
		end
		if (job_valid && job_ready)
			job_s2 <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			pend_s2     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_valid && job_ready) begin
				s2_valid_q <= 1'b1;
				pend_s2    <= job.mask;
			end else if (emit) begin
				pend_s2 <= rem;
				if (s2_done)
					s2_valid_q <= 1'b0;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (quad.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign quad.valid             = out_valid_q;
	assign quad.quad_top_left     = tl_q;
	assign quad.quad_top_right    = tr_q;
	assign quad.quad_bottom_left  = bl_q;
	assign quad.quad_bottom_right = br_q;
	assign quad.quad_row          = qrow_q;
	assign quad.quad_column       = qcol_q;
	assign quad.last_of_run       = last_q;
	assign quad.frame_done        = done_q;

endmodule

@@ hw/rtl/image_upscale_2x_linear_top.sv @@
// ----------------------------------------------------------------------------
// image_upscale_2x_linear_top
// 2x upscaler: raster pixels in, 2x2 output quads with source coordinates out.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  pix      in   pixel
//  quad     out  four quad pixels, quad_row, quad_column, last_of_run,
//                frame_done
//  cfg      in   index, data (0 interp_mode, 1 source_width, 2 source_height)
//
//  One pixel in and one quad out per cycle while quad.ready is high. A pixel
//  causing more than one quad holds the quad sequencer until all are out, so
//  the edge column and bottom row run at the quad rate. Line buffer: one
//  read-first port, read and written on the accept edge. No clearing pass
//  after reset. Stalls on quad back up through s1, s2 and out to pix.ready.
// ----------------------------------------------------------------------------
module image_upscale_2x_linear_top (
	input  logic       clk,
	input  logic       arst_n,
	ius_pixel_if.sink  pix,
	ius_quad_if.source quad,
	ius_cfg_if.sink    cfg
);

	logic                         interp_mode_q;
	logic [ius_pkg::SIZE_W-1:0]   width_q;
	logic [ius_pkg::SIZE_W-1:0]   height_q;
	ius_pkg::cfg_t                cfg_live;
	logic                         job_valid;
	logic                         job_ready;
	ius_pkg::quad_job_t           job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_mode_q <= 1'b1;
			width_q       <= ius_pkg::SIZE_W'(1024);
			height_q      <= ius_pkg::SIZE_W'(1024);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ius_pkg::REG_INTERP_MODE:   interp_mode_q <= cfg.data[0];
				ius_pkg::REG_SOURCE_WIDTH:  width_q       <= cfg.data;
				ius_pkg::REG_SOURCE_HEIGHT: height_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_live.interp_mode = interp_mode_q;
		cfg_live.col_last    = ius_pkg::col_last_idx(width_q);
		cfg_live.row_last    = ius_pkg::row_last_idx(height_q);
	end

	ius_line_buf u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_live),
		.pix       (pix),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready)
	);

	ius_quad_seq u_quad_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.quad      (quad)
	);

endmodule

@@ hw/rtl/ius_checker.sv @@
// ----------------------------------------------------------------------------
// ius_checker
// Port-level checks of the upscaler output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ius_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        quad_valid,
	input logic                        quad_ready,
	input logic [ius_pkg::PIX_W-1:0]   quad_top_left,
	input logic [ius_pkg::COORD_W-1:0] quad_row,
	input logic [ius_pkg::COORD_W-1:0] quad_column,
	input logic                        last_of_run,
	input logic                        frame_done
);

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, quad_valid && !quad_ready, quad_valid && $stable(quad_top_left) && $stable(quad_row) && $stable(quad_column))
	`ASSERT_IMPLY(a_done_ends_run, clk, arst_n, quad_valid && frame_done, last_of_run)
	`ASSERT_IMPLY(a_done_not_origin, clk, arst_n, quad_valid && frame_done, quad_row != '0 && quad_column != '0)
	`ASSERT_NEXT(a_run_continues, clk, arst_n, quad_valid && quad_ready && !last_of_run, quad_valid)

endmodule

bind image_upscale_2x_linear_top ius_checker u_ius_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.quad_valid    (quad.valid),
	.quad_ready    (quad.ready),
	.quad_top_left (quad.quad_top_left),
	.quad_row      (quad.quad_row),
	.quad_column   (quad.quad_column),
	.last_of_run   (quad.last_of_run),
	.frame_done    (quad.frame_done)
);
